[rtl/core/cmst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmst_pkg
// Shared constants and types for the counting multiset table.
// ----------------------------------------------------------------------------
package cmst_pkg;

    localparam int DEFAULT_DEPTH    = 256;
    localparam int DEFAULT_KEY_BITS = 32;
    localparam int ACTION_W         = 4;
    localparam int FIELD_W          = 32;
    localparam int INDEX_W          = 8;
    localparam int DISTINCT_W       = 9;

    localparam logic [ACTION_W-1:0] ACT_INSERT     = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_ERASE_ONE  = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_ERASE_ALL  = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_COUNT      = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_COUNT_GT   = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_COUNT_LT   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_REPLACE    = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_GET_INDEX  = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_LEAST_FREQ = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_SMALLEST   = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_SECOND     = 4'd10;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [FIELD_W-1:0]  key;
        logic [FIELD_W-1:0]  new_key;
        logic [INDEX_W-1:0]  index;
    } req_t;

    typedef struct packed {
        logic                  ok;
        logic [FIELD_W-1:0]    result_count;
        logic [FIELD_W-1:0]    result_key;
        logic [FIELD_W-1:0]    total_items;
        logic [DISTINCT_W-1:0] distinct_items;
    } rsp_t;

endpackage

[rtl/core/cmst_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmst_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface cmst_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/cmst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmst_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write the addressed word when enabled; always read it (old data on a write)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/core/counting_multiset_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_multiset_table_top
// Ordered table of distinct keys with occurrence counts and running totals.
// ----------------------------------------------------------------------------
// Each transaction is handled alone by a sequencer around two single-port
// RAMs (keys and counts, one read or write per cycle each). A scan (search,
// sums, minima) issues a read of each entry visited (S_RD), checks it
// (S_CHK) and closes in S_WR; removing an entry reads each following entry
// (S_SHRD) and writes it down one place (S_SHWR). Least frequent and second
// smallest make two scans, and a merging replace two searches followed by
// a merged-count write and a removal. The result is held in an output
// register; the next request is taken in the cycle after it has been
// delivered.
module counting_multiset_table_top #(
    parameter int TABLE_DEPTH = cmst_pkg::DEFAULT_DEPTH,
    parameter int KEY_BITS    = cmst_pkg::DEFAULT_KEY_BITS
) (
    input logic clk,
    input logic rst_n,
    cmst_stream_if.sink   req,
    cmst_stream_if.source rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int FW = cmst_pkg::FIELD_W;
    localparam logic [FW-1:0] CMAX = '1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_SRCH2 = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_SHRD  = 4'd5;
    localparam logic [3:0] S_SHWR  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_RMW   = 4'd8;

    // Pass-type codes for the scanning sequencer
    localparam logic [2:0] P_FIND  = 3'd0;
    localparam logic [2:0] P_FIND2 = 3'd1;
    localparam logic [2:0] P_SUM   = 3'd2;
    localparam logic [2:0] P_MINC  = 3'd3;
    localparam logic [2:0] P_TIEC  = 3'd4;
    localparam logic [2:0] P_MINK  = 3'd5;
    localparam logic [2:0] P_MINK2 = 3'd6;

    logic [3:0]        state_reg, state_next;
    logic [2:0]        pass_reg, pass_next;
    cmst_pkg::req_t    cur_reg, cur_next;
    logic [KEY_BITS-1:0] k_reg, k_next, nk_reg, nk_next;
    logic [CW-1:0]     dist_reg, dist_next;
    logic [FW-1:0]     total_reg, total_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     p_reg, p_next;
    logic              pf_reg, pf_next;
    logic [FW-1:0]     pc_reg, pc_next;
    logic [FW-1:0]     acc_reg, acc_next;
    logic [KEY_BITS-1:0] sk_reg, sk_next, tk_reg, tk_next;
    logic              have_reg, have_next;
    logic [1:0]        ties_reg, ties_next;
    cmst_pkg::rsp_t    out_reg, out_next;
    logic              ov_reg, ov_next;

    logic              k_we, c_we;
    logic [AW-1:0]     addr;
    logic [KEY_BITS-1:0] k_wd, k_rd;
    logic [FW-1:0]     c_wd, c_rd;

    cmst_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_keys (
        .clk(clk), .we(k_we), .addr(addr), .wdata(k_wd), .rdata(k_rd));
    cmst_ram #(.WIDTH(FW), .DEPTH(TABLE_DEPTH)) u_counts (
        .clk(clk), .we(c_we), .addr(addr), .wdata(c_wd), .rdata(c_rd));

    assign req.ready = (state_reg == S_IDLE) && !ov_reg;
    assign rsp.valid = ov_reg;
    assign rsp.payload = out_reg;

    // Widen a key to the result field
    function automatic logic [FW-1:0] kext(input logic [KEY_BITS-1:0] v);
        logic [FW+KEY_BITS-1:0] w;
        w = {{FW{1'b0}}, v};
        return w[FW-1:0];
    endfunction

    // Sequencer
    always_comb
    begin
        logic hit;
        logic [CW-1:0] dm1;
        state_next = state_reg; pass_next = pass_reg; cur_next = cur_reg;
        k_next = k_reg; nk_next = nk_reg; dist_next = dist_reg;
        total_next = total_reg; i_next = i_reg; p_next = p_reg;
        pf_next = pf_reg; pc_next = pc_reg; acc_next = acc_reg;
        sk_next = sk_reg; tk_next = tk_reg; have_next = have_reg;
        ties_next = ties_reg; out_next = out_reg; ov_next = ov_reg;
        k_we = 1'b0; c_we = 1'b0; addr = i_reg[AW-1:0];
        k_wd = k_reg; c_wd = c_rd; hit = 1'b0;
        dm1 = dist_reg - CW'(1);
        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end
        out_next.total_items = total_reg;
        out_next.distinct_items = cmst_pkg::DISTINCT_W'(dist_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && !ov_reg)
                begin
                    cur_next = req.payload;
                    k_next = KEY_BITS'(req.payload.key);
                    nk_next = KEY_BITS'(req.payload.new_key);
                    i_next = '0; pf_next = 1'b0; acc_next = '0;
                    have_next = 1'b0; ties_next = '0;
                    out_next.ok = 1'b0; out_next.result_count = '0;
                    out_next.result_key = '0;
                    state_next = S_RD;
                    case (req.payload.action)
                        cmst_pkg::ACT_COUNT_GT, cmst_pkg::ACT_COUNT_LT:
                            pass_next = P_SUM;
                        cmst_pkg::ACT_LEAST_FREQ: pass_next = P_MINC;
                        cmst_pkg::ACT_SMALLEST, cmst_pkg::ACT_SECOND:
                            pass_next = P_MINK;
                        cmst_pkg::ACT_GET_INDEX:
                        begin
                            if ({{(CW+1){1'b0}}, req.payload.index} <
                                {{(cmst_pkg::INDEX_W+1){1'b0}}, dist_reg})
                            begin
                                i_next = CW'(req.payload.index);
                                state_next = S_SRCH2;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        cmst_pkg::ACT_INSERT, cmst_pkg::ACT_ERASE_ONE,
                        cmst_pkg::ACT_ERASE_ALL, cmst_pkg::ACT_COUNT,
                        cmst_pkg::ACT_REPLACE: pass_next = P_FIND;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_SRCH2:
            begin
                // Registered read of the indexed entry
                state_next = S_RMW;
            end
            S_RMW:
            begin
                out_next.ok = 1'b1;
                out_next.result_key = kext(k_rd);
                out_next.result_count = c_rd;
                state_next = S_OUT;
            end
            S_RD:
            begin
                // Issue read of entry i, or finish the pass
                if (i_reg >= dist_reg || (pass_reg == P_FIND && pf_reg)
                    || (pass_reg == P_FIND2 && pf_reg))
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                i_next = i_reg + CW'(1);
                state_next = S_RD;
                case (pass_reg)
                    P_FIND:
                    begin
                        if (k_rd == k_reg)
                        begin
                            pf_next = 1'b1; p_next = i_reg; pc_next = c_rd;
                        end
                    end
                    P_FIND2:
                    begin
                        if (k_rd == nk_reg)
                        begin
                            pf_next = 1'b1; i_next = i_reg;
                        end
                    end
                    P_SUM:
                    begin
                        hit = (cur_reg.action == cmst_pkg::ACT_COUNT_GT) ?
                              (k_rd > k_reg) : (k_rd < k_reg);
                        if (hit)
                        begin
                            acc_next = acc_reg + c_rd;
                        end
                    end
                    P_MINC:
                    begin
                        if (i_reg == '0 || c_rd < acc_reg)
                        begin
                            acc_next = c_rd;
                        end
                    end
                    P_TIEC:
                    begin
                        if (c_rd == acc_reg)
                        begin
                            if (ties_reg == '0)
                            begin
                                sk_next = k_rd;
                            end
                            if (ties_reg != 2'd2)
                            begin
                                ties_next = ties_reg + 2'd1;
                            end
                        end
                    end
                    P_MINK:
                    begin
                        if (i_reg == '0 || k_rd < sk_reg)
                        begin
                            sk_next = k_rd;
                        end
                    end
                    default:
                    begin
                        if (k_rd != sk_reg && (!have_reg || k_rd < tk_reg))
                        begin
                            tk_next = k_rd; have_next = 1'b1;
                        end
                    end
                endcase
            end
            S_WR:
            begin
                // End of a pass: decide, modify, or start another pass
                state_next = S_OUT;
                i_next = '0;
                case (pass_reg)
                    P_FIND:
                    begin
                        case (cur_reg.action)
                            cmst_pkg::ACT_INSERT:
                            begin
                                if (total_reg != CMAX)
                                begin
                                    if (pf_reg && pc_reg != CMAX)
                                    begin
                                        addr = p_reg[AW-1:0];
                                        c_we = 1'b1; c_wd = pc_reg + FW'(1);
                                        total_next = total_reg + FW'(1);
                                        out_next.ok = 1'b1;
                                        out_next.result_count = FW'(1);
                                    end
                                    else if (!pf_reg &&
                                             dist_reg < CW'(TABLE_DEPTH))
                                    begin
                                        addr = dist_reg[AW-1:0];
                                        k_we = 1'b1; c_we = 1'b1;
                                        k_wd = k_reg; c_wd = FW'(1);
                                        dist_next = dist_reg + CW'(1);
                                        total_next = total_reg + FW'(1);
                                        out_next.ok = 1'b1;
                                        out_next.result_count = FW'(1);
                                    end
                                end
                            end
                            cmst_pkg::ACT_COUNT:
                            begin
                                out_next.ok = pf_reg;
                                out_next.result_count = pf_reg ? pc_reg : '0;
                            end
                            cmst_pkg::ACT_ERASE_ONE, cmst_pkg::ACT_ERASE_ALL:
                            begin
                                if (pf_reg)
                                begin
                                    out_next.ok = 1'b1;
                                    if (cur_reg.action == cmst_pkg::ACT_ERASE_ONE
                                        && pc_reg > FW'(1))
                                    begin
                                        addr = p_reg[AW-1:0];
                                        c_we = 1'b1; c_wd = pc_reg - FW'(1);
                                        total_next = total_reg - FW'(1);
                                        out_next.result_count = FW'(1);
                                    end
                                    else
                                    begin
                                        total_next = total_reg - pc_reg;
                                        out_next.result_count = pc_reg;
                                        i_next = p_reg;
                                        state_next = S_SHRD;
                                    end
                                end
                            end
                            default:
                            begin
                                // Replace
                                if (pf_reg)
                                begin
                                    out_next.ok = 1'b1;
                                    if (nk_reg != k_reg)
                                    begin
                                        pass_next = P_FIND2;
                                        pf_next = 1'b0;
                                        state_next = S_RD;
                                    end
                                end
                            end
                        endcase
                    end
                    P_FIND2:
                    begin
                        if (pf_reg)
                        begin
                            // Merge count into the entry of new_key (read)
                            addr = i_reg[AW-1:0];
                            state_next = S_SRCH2;
                            pass_next = P_MINK2;
                            cur_next.action = cmst_pkg::ACT_REPLACE;
                            i_next = i_reg;
                        end
                        else
                        begin
                            addr = p_reg[AW-1:0];
                            k_we = 1'b1; k_wd = nk_reg;
                        end
                    end
                    P_SUM:
                    begin
                        out_next.ok = 1'b1;
                        out_next.result_count = acc_reg;
                    end
                    P_MINC:
                    begin
                        if (dist_reg != '0)
                        begin
                            pass_next = P_TIEC;
                            state_next = S_RD;
                        end
                    end
                    P_TIEC:
                    begin
                        if (ties_reg == 2'd1)
                        begin
                            out_next.ok = 1'b1;
                            out_next.result_key = kext(sk_reg);
                            out_next.result_count = acc_reg;
                        end
                    end
                    P_MINK:
                    begin
                        if (cur_reg.action == cmst_pkg::ACT_SMALLEST)
                        begin
                            if (dist_reg != '0)
                            begin
                                out_next.ok = 1'b1;
                                out_next.result_key = kext(sk_reg);
                            end
                        end
                        else if (dist_reg > CW'(1))
                        begin
                            pass_next = P_MINK2;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        out_next.ok = 1'b1;
                        out_next.result_key = kext(tk_reg);
                    end
                endcase
                // Merge path: intercept after the registered read
                if (pass_reg == P_FIND2 && pf_reg)
                begin
                    state_next = S_SHWR;
                    pass_next = P_FIND2;
                end
            end
            S_SHWR:
            begin
                if (pass_reg == P_FIND2)
                begin
                    // Write merged count, then remove the original entry
                    addr = i_reg[AW-1:0];
                    c_we = 1'b1; c_wd = c_rd + pc_reg;
                    i_next = p_reg;
                    pass_next = P_FIND;
                    state_next = S_SHRD;
                end
                else
                begin
                    // Write the moved entry down one place
                    addr = i_reg[AW-1:0];
                    k_we = 1'b1; c_we = 1'b1; k_wd = k_rd; c_wd = c_rd;
                    i_next = i_reg + CW'(1);
                    state_next = S_SHRD;
                end
            end
            S_SHRD:
            begin
                // Read the next entry, or drop the last one
                if (i_reg + CW'(1) < dist_reg)
                begin
                    addr = AW'(i_reg + CW'(1));
                    pass_next = P_SUM;
                    state_next = S_SHWR;
                end
                else
                begin
                    dist_next = dm1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_next.total_items = total_reg;
                out_next.distinct_items = cmst_pkg::DISTINCT_W'(dist_reg);
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
            dist_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            dist_reg <= dist_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg <= pass_next; cur_reg <= cur_next; k_reg <= k_next;
        nk_reg <= nk_next; i_reg <= i_next; p_reg <= p_next; pf_reg <= pf_next;
        pc_reg <= pc_next; acc_reg <= acc_next; sk_reg <= sk_next;
        tk_reg <= tk_next; have_reg <= have_next; ties_reg <= ties_next;
        out_reg <= out_next;
    end
endmodule

[bench/counting_multiset_table_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_multiset_table_top_tb
// Self-checking bench for the counting multiset table. Directed tests cover
// empty-table queries, key extremes, merging replace, position reads, ties
// and a full table. A long random phase follows that mostly reuses a small
// pool of keys so that entries collide. Each response is checked field by
// field against an in-bench table model, in order.
// ----------------------------------------------------------------------------
module counting_multiset_table_top_tb;

    localparam int DEPTH = cmst_pkg::DEFAULT_DEPTH;
    localparam int POOL  = 20;

    logic clk;
    logic rst_n;

    cmst_stream_if #(.payload_t(cmst_pkg::req_t)) req_if ();
    cmst_stream_if #(.payload_t(cmst_pkg::rsp_t)) rsp_if ();

    counting_multiset_table_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Model of the table contents
    logic [31:0] tbl_key [DEPTH];
    logic [31:0] tbl_cnt [DEPTH];
    int          tbl_used;
    logic [31:0] tbl_total;

    cmst_pkg::rsp_t pending_rsp[$];
    int          mismatches;
    bit          quiet;
    int          rsp_stall;
    logic [31:0] key_pool [POOL];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Hold the run to a bounded time
    initial
    begin
        #100_000_000;
        $display("counting_multiset_table_top regression: fail");
        $finish;
    end

    function automatic int find_entry(logic [31:0] k);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    task automatic drop_entry(int pos);
        for (int i = pos; i + 1 < tbl_used; i++)
        begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_cnt[i] = tbl_cnt[i + 1];
        end
        tbl_used--;
    endtask

    // Apply one transaction to the table model and build the response
    task automatic apply_action(input cmst_pkg::req_t r, output cmst_pkg::rsp_t e);
        int          p;
        int          q;
        int          ties;
        int          at;
        logic [31:0] low;
        logic [31:0] s;
        logic [31:0] t;
        bit          have;
        e = '0;
        p = find_entry(r.key);
        case (r.action)
            cmst_pkg::ACT_INSERT:
            begin
                if (tbl_total != 32'hFFFF_FFFF)
                begin
                    if (p >= 0)
                    begin
                        if (tbl_cnt[p] != 32'hFFFF_FFFF)
                        begin
                            tbl_cnt[p]++;
                            tbl_total++;
                            e.ok = 1'b1;
                        end
                    end
                    else if (tbl_used < DEPTH)
                    begin
                        tbl_key[tbl_used] = r.key;
                        tbl_cnt[tbl_used] = 1;
                        tbl_used++;
                        tbl_total++;
                        e.ok = 1'b1;
                    end
                end
                e.result_count = {31'b0, e.ok};
            end
            cmst_pkg::ACT_ERASE_ONE:
            begin
                if (p >= 0)
                begin
                    if (tbl_cnt[p] > 1)
                        tbl_cnt[p]--;
                    else
                        drop_entry(p);
                    tbl_total--;
                    e.ok = 1'b1;
                    e.result_count = 1;
                end
            end
            cmst_pkg::ACT_ERASE_ALL:
            begin
                if (p >= 0)
                begin
                    e.result_count = tbl_cnt[p];
                    drop_entry(p);
                    tbl_total -= e.result_count;
                    e.ok = 1'b1;
                end
            end
            cmst_pkg::ACT_COUNT:
            begin
                if (p >= 0)
                begin
                    e.ok = 1'b1;
                    e.result_count = tbl_cnt[p];
                end
            end
            cmst_pkg::ACT_COUNT_GT, cmst_pkg::ACT_COUNT_LT:
            begin
                e.ok = 1'b1;
                for (int i = 0; i < tbl_used; i++)
                    if ((r.action == cmst_pkg::ACT_COUNT_GT) ? (tbl_key[i] > r.key)
                                                             : (tbl_key[i] < r.key))
                        e.result_count += tbl_cnt[i];
            end
            cmst_pkg::ACT_REPLACE:
            begin
                if (p >= 0)
                begin
                    e.ok = 1'b1;
                    if (r.new_key != r.key)
                    begin
                        q = find_entry(r.new_key);
                        if (q >= 0)
                        begin
                            tbl_cnt[q] += tbl_cnt[p];
                            drop_entry(p);
                        end
                        else
                            tbl_key[p] = r.new_key;
                    end
                end
            end
            cmst_pkg::ACT_GET_INDEX:
            begin
                if (int'(r.index) < tbl_used)
                begin
                    e.ok = 1'b1;
                    e.result_key = tbl_key[r.index];
                    e.result_count = tbl_cnt[r.index];
                end
            end
            cmst_pkg::ACT_LEAST_FREQ:
            begin
                if (tbl_used > 0)
                begin
                    low = tbl_cnt[0];
                    ties = 0;
                    at = 0;
                    for (int i = 0; i < tbl_used; i++)
                        if (tbl_cnt[i] < low)
                            low = tbl_cnt[i];
                    for (int i = 0; i < tbl_used; i++)
                        if (tbl_cnt[i] == low)
                        begin
                            if (ties == 0)
                                at = i;
                            ties++;
                        end
                    if (ties == 1)
                    begin
                        e.ok = 1'b1;
                        e.result_key = tbl_key[at];
                        e.result_count = low;
                    end
                end
            end
            cmst_pkg::ACT_SMALLEST, cmst_pkg::ACT_SECOND:
            begin
                if (tbl_used > ((r.action == cmst_pkg::ACT_SMALLEST) ? 0 : 1))
                begin
                    s = tbl_key[0];
                    for (int i = 1; i < tbl_used; i++)
                        if (tbl_key[i] < s)
                            s = tbl_key[i];
                    if (r.action == cmst_pkg::ACT_SMALLEST)
                        e.result_key = s;
                    else
                    begin
                        have = 1'b0;
                        t = '0;
                        for (int i = 0; i < tbl_used; i++)
                            if (tbl_key[i] != s && (!have || tbl_key[i] < t))
                            begin
                                t = tbl_key[i];
                                have = 1'b1;
                            end
                        e.result_key = t;
                    end
                    e.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        e.total_items = tbl_total;
        e.distinct_items = tbl_used[cmst_pkg::DISTINCT_W-1:0];
    endtask

    // Send one transaction; called at a rising edge, returns at a rising edge
    task automatic send_req(input logic [3:0] act, input logic [31:0] k,
                            input logic [31:0] nk, input logic [7:0] idx);
        cmst_pkg::req_t r;
        cmst_pkg::rsp_t e;
        int   gap;
        r.action = act;
        r.key = k;
        r.new_key = nk;
        r.index = idx;
        req_if.valid <= 1'b1;
        req_if.payload <= r;
        do
            @(negedge clk);
        while (!req_if.ready);
        @(posedge clk);
        apply_action(r, e);
        pending_rsp.push_back(e);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stall the response side in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_stall <= 0;
        end
        else if (rsp_stall > 0)
        begin
            rsp_if.ready <= 1'b0;
            rsp_stall <= rsp_stall - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            rsp_if.ready <= 1'b0;
            rsp_stall <= $urandom_range(0, 7);
        end
        else
            rsp_if.ready <= 1'b1;
    end

    // Compare each response with the oldest prediction
    always @(negedge clk)
    begin
        cmst_pkg::rsp_t e;
        cmst_pkg::rsp_t a;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            a = rsp_if.payload;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", a);
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (a.ok !== e.ok || a.result_count !== e.result_count
                    || a.result_key !== e.result_key
                    || a.total_items !== e.total_items
                    || a.distinct_items !== e.distinct_items)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, a);
                end
            end
        end
    end

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL - 1)];
        return $urandom;
    endfunction

    task automatic test_empty_queries();
        for (int a = 1; a <= 10; a++)
            send_req(a[3:0], 32'h5, 32'h6, 8'd0);
    endtask

    task automatic test_directed();
        send_req(cmst_pkg::ACT_INSERT, 32'h0, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_INSERT, 32'h8000_0000, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_INSERT, 32'h8000_0000, 32'h0, 8'd0);
        // tie on lowest count, then smallest and second smallest
        send_req(cmst_pkg::ACT_LEAST_FREQ, 32'h0, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_SMALLEST, 32'h0, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_SECOND, 32'h0, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_COUNT_GT, 32'h0, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_COUNT_LT, 32'hFFFF_FFFF, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_GET_INDEX, 32'h0, 32'h0, 8'd2);
        send_req(cmst_pkg::ACT_GET_INDEX, 32'h0, 32'h0, 8'd255);
        // replace by itself, onto an existing key, to a fresh key, missing key
        send_req(cmst_pkg::ACT_REPLACE, 32'h8000_0000, 32'h8000_0000, 8'd0);
        send_req(cmst_pkg::ACT_REPLACE, 32'h0, 32'h8000_0000, 8'd0);
        send_req(cmst_pkg::ACT_REPLACE, 32'hFFFF_FFFF, 32'h1234_5678, 8'd0);
        send_req(cmst_pkg::ACT_REPLACE, 32'h7, 32'h9, 8'd0);
        send_req(cmst_pkg::ACT_LEAST_FREQ, 32'h0, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_ERASE_ONE, 32'h8000_0000, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_COUNT, 32'h8000_0000, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_ERASE_ALL, 32'h8000_0000, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_ERASE_ONE, 32'h1234_5678, 32'h0, 8'd0);
        // unused action codes
        for (int a = 11; a <= 15; a++)
            send_req(a[3:0], 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    endtask

    task automatic test_full_table();
        logic [31:0] base;
        base = $urandom;
        for (int i = 0; i < DEPTH; i++)
            send_req(cmst_pkg::ACT_INSERT, base + i, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_INSERT, base + DEPTH, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_INSERT, base + 3, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_GET_INDEX, 32'h0, 32'h0, 8'd255);
        send_req(cmst_pkg::ACT_LEAST_FREQ, 32'h0, 32'h0, 8'd0);
        send_req(cmst_pkg::ACT_REPLACE, base + 7, base + 3, 8'd0);
        // drain from the front so every erase shifts the whole table
        while (tbl_used > 0)
            send_req(cmst_pkg::ACT_ERASE_ALL, tbl_key[0], 32'h0, 8'd0);
    endtask

    task automatic test_random(int n);
        int          w;
        logic [3:0]  act;
        logic [31:0] k;
        for (int i = 0; i < n; i++)
        begin
            if (i > n - 150)
                quiet = 1'b1;
            w = $urandom_range(0, 99);
            if (tbl_used > 24 && w < 40)
                act = cmst_pkg::ACT_ERASE_ALL;
            else if (w < 30)
                act = cmst_pkg::ACT_INSERT;
            else if (w < 97)
                act = 4'($urandom_range(1, 10));
            else
                act = 4'($urandom_range(11, 15));
            k = pick_key();
            if (tbl_used > 0 && $urandom_range(0, 1) == 1
                && act != cmst_pkg::ACT_INSERT)
                k = tbl_key[$urandom_range(0, tbl_used - 1)];
            send_req(act, k, pick_key(),
                     (tbl_used > 0 && $urandom_range(0, 3) != 0)
                         ? 8'($urandom_range(0, tbl_used - 1)) : 8'($urandom));
        end
    endtask

    initial
    begin
        mismatches = 0;
        quiet = 1'b0;
        tbl_used = 0;
        tbl_total = '0;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < POOL; i++)
            key_pool[i] = $urandom;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queries();
        test_directed();
        test_full_table();
        test_random(620);

        // Drain outstanding responses
        req_if.valid <= 1'b0;
        while (pending_rsp.size() > 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
        if (mismatches == 0)
            $display("counting_multiset_table_top regression: pass");
        else
            $display("counting_multiset_table_top regression: fail");
        $finish;
    end

endmodule

[files.f]
rtl/core/cmst_pkg.sv
rtl/core/cmst_stream_if.sv
rtl/core/cmst_ram.sv
rtl/core/counting_multiset_table_top.sv
bench/counting_multiset_table_top_tb.sv
